### rtl/lzr_pkg.sv
package lzr_pkg;

	localparam int RING_DEPTH = 8192;
	localparam int LEN_BITS   = 4;
	localparam int MIN_MATCH  = 3;
	localparam int LIT_BITS   = 8;
	localparam int SIZE_W     = 24;

	localparam int AW      = $clog2(RING_DEPTH);
	localparam int TOK_W   = AW + LEN_BITS;
	localparam int TCNT_W  = $clog2(TOK_W + 1);
	localparam int MAX_LEN = (1 << LEN_BITS) - 1 + MIN_MATCH;
	localparam int REM_W   = $clog2(MAX_LEN + 1);
	localparam int BLEFT_W = $clog2(LIT_BITS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BITS,
		ST_COPY,
		ST_FLUSH
	} state_t;

	typedef enum logic [1:0] {
		PH_FLAG,
		PH_LIT,
		PH_MATCH
	} phase_t;

	typedef struct packed {
		logic [LIT_BITS-1:0] data;
		logic                byte_valid;
		logic                finished;
		logic                success;
	} res_t;

endpackage

### rtl/lzss_ring_decompressor.sv
// Each word is taken, then decoded one bit at a time (8, and up to 30 zero padding bits after the
// last word), each match is copied through the ring RAM, and the word is closed.
// A new word is taken only once the last one is closed; the bit decoder, the copy and the
// close wait while the result buffer is full.
// Reset clears control state, pointer to 1, size register to 0; the ring RAM is not
// cleared, its unwritten entries are masked against the output count, so no clearing pass.
module lzss_ring_decompressor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [lzr_pkg::SIZE_W-1:0]    cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [lzr_pkg::LIT_BITS-1:0]  comp_byte,
	input  logic                          stream_start,
	input  logic                          stream_end,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lzr_pkg::LIT_BITS-1:0]  out_byte,
	output logic                          byte_valid,
	output logic                          run_last,
	output logic                          finished,
	output logic                          success
);
	import lzr_pkg::*;

	state_t              state_q, state_d;
	phase_t              phase_q, phase_d;
	logic [TOK_W-1:0]    acc_q, acc_d, acc_n;
	logic [TCNT_W-1:0]   tcnt_q, tcnt_d, tcnt_n;
	logic [AW-1:0]       wp_q, wp_d;
	logic [SIZE_W-1:0]   prod_q, prod_d, prod_n, prod_eff;
	logic                done_q, done_d;
	logic [SIZE_W-1:0]   size_q;
	logic [LIT_BITS-1:0] byte_q, byte_d;
	logic [BLEFT_W-1:0]  bleft_q, bleft_d;
	logic                pad_q, pad_d;
	logic [AW-1:0]       rd_addr_q, rd_addr_d, rd_prev;
	logic [REM_W-1:0]    rem_q, rem_d;
	logic                rvalid_s1, rvalid_d;
	logic                mark_s1;
	logic                fwd_s1;
	logic [LIT_BITS-1:0] fwd_data_s1;

	logic                in_acc;
	logic                buf_ready;
	logic                push;
	res_t                push_res;
	logic                flush;
	logic                put_en;
	logic [LIT_BITS-1:0] put_val;
	logic                mem_re;
	logic [LIT_BITS-1:0] rdata;
	logic                mark_rd;
	logic                fwd_hit;
	logic                bit_in;
	logic                bit_step;
	logic                go_copy;
	logic                copy_last;
	logic                status_acc;
	logic                more_bits;

	assign in_stall = !(state_q == ST_IDLE && buf_ready);
	assign in_acc   = in_valid && !in_stall;
	assign rd_prev  = rd_addr_q - AW'(1);

	// datapath
	always_comb begin
		phase_d    = phase_q;
		acc_d      = acc_q;
		tcnt_d     = tcnt_q;
		wp_d       = wp_q;
		prod_d     = prod_q;
		done_d     = done_q;
		byte_d     = byte_q;
		bleft_d    = bleft_q;
		pad_d      = pad_q;
		rd_addr_d  = rd_addr_q;
		rem_d      = rem_q;
		rvalid_d   = rvalid_s1;
		push       = 1'b0;
		push_res   = '0;
		flush      = 1'b0;
		put_en     = 1'b0;
		put_val    = '0;
		mem_re     = 1'b0;
		fwd_hit    = 1'b0;
		go_copy    = 1'b0;
		copy_last  = 1'b0;
		status_acc = 1'b0;
		bit_step   = 1'b0;
		bit_in     = (bleft_q != '0) ? byte_q[LIT_BITS-1] : 1'b0;
		acc_n      = {acc_q[TOK_W-2:0], bit_in};
		tcnt_n     = tcnt_q + TCNT_W'(1);
		prod_n     = prod_q + SIZE_W'(1);
		prod_eff   = stream_start ? '0 : prod_q;
		// entries 1..prod have been written since the stream started
		mark_rd    = (prod_q[SIZE_W-1:AW] != '0) || (rd_prev < prod_q[AW-1:0]);

		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (stream_start) begin
						phase_d = PH_FLAG;
						acc_d   = '0;
						tcnt_d  = '0;
						wp_d    = AW'(1);
						prod_d  = '0;
						done_d  = 1'b0;
					end
					byte_d  = comp_byte;
					bleft_d = BLEFT_W'(LIT_BITS);
					pad_d   = stream_end;
					if (!(done_q && !stream_start) && prod_eff >= size_q) begin
						done_d              = 1'b1;
						push                = 1'b1;
						push_res.finished   = 1'b1;
						push_res.success    = 1'b1;
						status_acc          = 1'b1;
					end
				end
			end
			ST_BITS: begin
				if (buf_ready) begin
					bit_step = 1'b1;
					bleft_d  = (bleft_q != '0) ? bleft_q - BLEFT_W'(1) : bleft_q;
					byte_d   = {byte_q[LIT_BITS-2:0], 1'b0};
					case (phase_q)
						PH_FLAG: begin
							acc_d   = '0;
							tcnt_d  = '0;
							phase_d = bit_in ? PH_LIT : PH_MATCH;
						end
						PH_LIT: begin
							acc_d  = acc_n;
							tcnt_d = tcnt_n;
							if (tcnt_n >= TCNT_W'(LIT_BITS)) begin
								phase_d = PH_FLAG;
								put_en  = 1'b1;
								put_val = acc_n[LIT_BITS-1:0];
							end
						end
						PH_MATCH: begin
							acc_d  = acc_n;
							tcnt_d = tcnt_n;
							if (tcnt_n == TCNT_W'(AW) && acc_n == '0) begin
								// terminator
								done_d            = 1'b1;
								phase_d           = PH_FLAG;
								push              = 1'b1;
								push_res.finished = 1'b1;
							end else if (tcnt_n >= TCNT_W'(TOK_W)) begin
								phase_d   = PH_FLAG;
								rd_addr_d = acc_n[TOK_W-1:LEN_BITS];
								rem_d     = REM_W'(acc_n[LEN_BITS-1:0]) + REM_W'(MIN_MATCH);
								rvalid_d  = 1'b0;
								go_copy   = 1'b1;
							end
						end
						default: begin
							phase_d = PH_FLAG;
						end
					endcase
				end
			end
			ST_COPY: begin
				if (buf_ready) begin
					if (rvalid_s1) begin
						put_en  = 1'b1;
						put_val = fwd_s1 ? fwd_data_s1 : (mark_s1 ? rdata : '0);
					end
					copy_last = (rem_q == '0);
					if (rem_q != '0) begin
						mem_re    = 1'b1;
						rd_addr_d = rd_addr_q + AW'(1);
						rem_d     = rem_q - REM_W'(1);
						rvalid_d  = 1'b1;
						// read of the entry written on the same edge returns old data
						fwd_hit   = put_en && (wp_q == rd_addr_q);
					end else begin
						rvalid_d = 1'b0;
					end
				end
			end
			ST_FLUSH: begin
				flush = buf_ready;
			end
			default: begin
			end
		endcase

		if (put_en) begin
			wp_d                = wp_q + AW'(1);
			prod_d              = prod_n;
			push                = 1'b1;
			push_res.data       = put_val;
			push_res.byte_valid = 1'b1;
			if (prod_n >= size_q) begin
				done_d            = 1'b1;
				push_res.finished = 1'b1;
				push_res.success  = 1'b1;
			end
		end
	end

	assign more_bits = (bleft_d != '0) || pad_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (status_acc) begin
						state_d = ST_FLUSH;
					end else if (!(done_q && !stream_start)) begin
						state_d = ST_BITS;
					end
				end
			end
			ST_BITS: begin
				if (bit_step) begin
					if (done_d) begin
						state_d = ST_FLUSH;
					end else if (go_copy) begin
						state_d = ST_COPY;
					end else if (!more_bits) begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_COPY: begin
				if (buf_ready) begin
					if (done_d) begin
						state_d = ST_FLUSH;
					end else if (copy_last) begin
						state_d = more_bits ? ST_BITS : ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				if (buf_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= PH_FLAG;
			acc_q     <= '0;
			tcnt_q    <= '0;
			wp_q      <= AW'(1);
			prod_q    <= '0;
			done_q    <= 1'b0;
			size_q    <= '0;
			bleft_q   <= '0;
			pad_q     <= 1'b0;
			rem_q     <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			phase_q   <= phase_d;
			acc_q     <= acc_d;
			tcnt_q    <= tcnt_d;
			wp_q      <= wp_d;
			prod_q    <= prod_d;
			done_q    <= done_d;
			bleft_q   <= bleft_d;
			pad_q     <= pad_d;
			rem_q     <= rem_d;
			rvalid_s1 <= rvalid_d;
			if (cfg_wr_en) begin
				size_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		byte_q    <= byte_d;
		rd_addr_q <= rd_addr_d;
		if (mem_re) begin
			mark_s1     <= mark_rd;
			fwd_s1      <= fwd_hit;
			fwd_data_s1 <= put_val;
		end
	end

	lzr_ring_ram #(
		.DEPTH (RING_DEPTH),
		.WIDTH (LIT_BITS)
	) u_ring (
		.clk   (clk),
		.we    (put_en),
		.waddr (wp_q),
		.wdata (put_val),
		.re    (mem_re),
		.raddr (rd_addr_q),
		.rdata (rdata)
	);

	lzr_result_buf u_res (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_res   (push_res),
		.flush      (flush),
		.ready      (buf_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.run_last   (run_last),
		.finished   (finished),
		.success    (success)
	);

	a_quiet_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && state_q != ST_IDLE) |-> (!push && !put_en))
		else $error("output after stream finished");

	a_copy_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY && !rvalid_s1) |-> (rem_q != '0))
		else $error("copy with nothing in flight");

	a_wp_step: assert property (@(posedge clk) disable iff (!arst_n)
		put_en |=> ((wp_q - $past(wp_q)) == AW'(1)))
		else $error("write pointer did not advance");

endmodule

### rtl/lzr_ring_ram.sv
module lzr_ring_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/lzr_result_buf.sv
module lzr_result_buf (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  lzr_pkg::res_t                    push_res,
	input  logic                             flush,
	output logic                             ready,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [lzr_pkg::LIT_BITS-1:0]     out_byte,
	output logic                             byte_valid,
	output logic                             run_last,
	output logic                             finished,
	output logic                             success
);
	import lzr_pkg::*;

	res_t pend_q;
	res_t out_q;
	logic pend_v_q;
	logic out_v_q;
	logic last_q;
	logic out_free;
	logic move;

	assign out_free = !out_v_q || !out_stall;
	assign ready    = !pend_v_q || out_free;
	// pending word goes out once the next one arrives or the input word is done
	assign move     = pend_v_q && (push || flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (push) begin
				pend_v_q <= 1'b1;
			end else if (flush) begin
				pend_v_q <= 1'b0;
			end
			if (move) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			pend_q <= push_res;
		end
		if (move) begin
			out_q  <= pend_q;
			last_q <= flush;
		end
	end

	assign out_valid  = out_v_q;
	assign out_byte   = out_q.data;
	assign byte_valid = out_q.byte_valid;
	assign run_last   = last_q;
	assign finished   = out_q.finished;
	assign success    = out_q.success;

	a_push_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(push || flush) |-> ready)
		else $error("result pushed while buffer full");

	a_push_flush: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && flush))
		else $error("push and flush together");

	a_flush_empty: assert property (@(posedge clk) disable iff (!arst_n)
		flush |=> !pend_v_q)
		else $error("pending word left after flush");

endmodule

### test/lzss_ring_decompressor_tb.sv
module lzss_ring_decompressor_tb;
	import lzr_pkg::*;

	localparam int IDLE_LIMIT    = 5000;
	localparam int SETTLE_CYCLES = 100;
	localparam int WORD_TARGET   = 380;

	typedef struct {
		logic [LIT_BITS-1:0] data;
		logic                byte_valid;
		logic                run_last;
		logic                finished;
		logic                success;
	} out_rec_t;

	class lzss_scoreboard;
		logic [LIT_BITS-1:0] ring_mem [RING_DEPTH];
		bit                  ring_seen [RING_DEPTH];
		logic [AW-1:0]       ring_wp;
		logic [TOK_W-1:0]    tok_bits;
		int                  tok_len;
		phase_t              tok_phase;
		logic [SIZE_W-1:0]   out_count;
		logic [SIZE_W-1:0]   size_limit;
		bit                  halted;
		out_rec_t            word_out[$];
		out_rec_t            pending_bytes[$];
		int                  n_fail;

		function new();
			foreach (ring_mem[i]) ring_mem[i] = '0;
			size_limit = '0;
			n_fail = 0;
			restart();
		endfunction

		// ring contents survive a restart, only the marks are cleared
		function void restart();
			foreach (ring_seen[i]) ring_seen[i] = 1'b0;
			ring_wp = 1;
			tok_bits = '0;
			tok_len = 0;
			tok_phase = PH_FLAG;
			out_count = '0;
			halted = 1'b0;
		endfunction

		function void emit(logic [LIT_BITS-1:0] d, logic v, logic f, logic s);
			out_rec_t r;
			r.data = d;
			r.byte_valid = v;
			r.run_last = 1'b0;
			r.finished = f;
			r.success = s;
			word_out = {word_out, r};
		endfunction

		function void put_byte(logic [LIT_BITS-1:0] v);
			ring_mem[ring_wp] = v;
			ring_seen[ring_wp] = 1'b1;
			ring_wp = ring_wp + AW'(1);
			out_count = out_count + SIZE_W'(1);
			if (out_count >= size_limit) begin
				halted = 1'b1;
				emit(v, 1'b1, 1'b1, 1'b1);
			end else begin
				emit(v, 1'b1, 1'b0, 1'b0);
			end
		endfunction

		function void feed_bit(logic b);
			logic [AW-1:0] pos;
			int n;
			int i;
			if (tok_phase == PH_FLAG) begin
				tok_bits = '0;
				tok_len = 0;
				tok_phase = b ? PH_LIT : PH_MATCH;
				return;
			end
			tok_bits = {tok_bits[TOK_W-2:0], b};
			tok_len++;
			if (tok_phase == PH_LIT) begin
				if (tok_len >= LIT_BITS) begin
					tok_phase = PH_FLAG;
					put_byte(tok_bits[LIT_BITS-1:0]);
				end
				return;
			end
			// position zero is the terminator
			if (tok_len == AW && tok_bits == '0) begin
				halted = 1'b1;
				tok_phase = PH_FLAG;
				emit('0, 1'b0, 1'b1, 1'b0);
				return;
			end
			if (tok_len >= TOK_W) begin
				pos = tok_bits[TOK_W-1:LEN_BITS];
				n = int'(tok_bits[LEN_BITS-1:0]) + MIN_MATCH;
				tok_phase = PH_FLAG;
				for (i = 0; i < n && !halted; i++) begin
					put_byte(ring_seen[pos] ? ring_mem[pos] : '0);
					pos = pos + AW'(1);
				end
			end
		endfunction

		function void decode_word(logic [LIT_BITS-1:0] b, logic s, logic e);
			int k;
			word_out.delete();
			if (s) begin
				restart();
			end
			if (halted) begin
				return;
			end
			if (out_count >= size_limit) begin
				halted = 1'b1;
				emit('0, 1'b0, 1'b1, 1'b1);
			end else begin
				for (k = LIT_BITS - 1; k >= 0 && !halted; k--) feed_bit(b[k]);
				if (e) begin
					for (k = 0; k < 256 && !halted; k++) feed_bit(1'b0);
				end
			end
			if (word_out.size() > 0) begin
				word_out[word_out.size() - 1].run_last = 1'b1;
			end
			pending_bytes = {pending_bytes, word_out};
		endfunction

		function void compare(string name, logic [LIT_BITS-1:0] want, logic [LIT_BITS-1:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				n_fail++;
			end
		endfunction

		function void check_output(out_rec_t got);
			out_rec_t want;
			if (pending_bytes.size() == 0) begin
				$error("output word with nothing pending: out_byte %0h", got.data);
				n_fail++;
				return;
			end
			want = pending_bytes.pop_front();
			compare("out_byte", want.data, got.data);
			compare("byte_valid", want.byte_valid, got.byte_valid);
			compare("run_last", want.run_last, got.run_last);
			compare("finished", want.finished, got.finished);
			compare("success", want.success, got.success);
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [SIZE_W-1:0]   cfg_wr_data;
	logic                in_valid;
	logic                in_stall;
	logic [LIT_BITS-1:0] comp_byte;
	logic                stream_start;
	logic                stream_end;
	logic                out_valid;
	logic                out_stall;
	logic [LIT_BITS-1:0] out_byte;
	logic                byte_valid;
	logic                run_last;
	logic                finished;
	logic                success;

	lzss_scoreboard sb;
	bit tx_bits[$];
	int words_sent = 0;
	int src_idle_pct = 21;
	int sink_stall_pct = 87;
	int idle_cycles = 0;

	lzss_ring_decompressor u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.comp_byte    (comp_byte),
		.stream_start (stream_start),
		.stream_end   (stream_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.run_last     (run_last),
		.finished     (finished),
		.success      (success)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < sink_stall_pct);
	end

	always @(posedge clk) begin : monitor
		out_rec_t got;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				sb.decode_word(comp_byte, stream_start, stream_end);
			end
			if (out_valid && !out_stall) begin
				got.data = out_byte;
				got.byte_valid = byte_valid;
				got.run_last = run_last;
				got.finished = finished;
				got.success = success;
				sb.check_output(got);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic send_word(logic [LIT_BITS-1:0] b, logic s, logic e);
		if (words_sent < WORD_TARGET / 3) begin
			src_idle_pct = 21;
			sink_stall_pct = 87;
		end else if (words_sent < 2 * WORD_TARGET / 3) begin
			src_idle_pct = 87;
			sink_stall_pct = 21;
		end else begin
			src_idle_pct = 0;
			sink_stall_pct = 0;
		end
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		comp_byte <= b;
		stream_start <= s;
		stream_end <= e;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	// drop valid, drain, then allow for a word still decoding with no output
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending_bytes.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_size(logic [SIZE_W-1:0] v);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.size_limit = v;
	endtask

	function automatic void push_field(int unsigned v, int w);
		int i;
		for (i = w - 1; i >= 0; i--) tx_bits = {tx_bits, v[i]};
	endfunction

	function automatic void push_literal(int unsigned v);
		push_field(1, 1);
		push_field(v, LIT_BITS);
	endfunction

	function automatic void push_match(int unsigned pos, int unsigned len);
		push_field(0, 1);
		push_field(pos, AW);
		push_field(len, LEN_BITS);
	endfunction

	function automatic void push_terminator();
		push_field(0, 1);
		push_field(0, AW);
	endfunction

	task automatic send_packed(bit s, bit e);
		logic [LIT_BITS-1:0] b;
		int n;
		int i;
		int k;
		while (tx_bits.size() % LIT_BITS != 0) tx_bits = {tx_bits, bit'($urandom_range(1))};
		n = tx_bits.size() / LIT_BITS;
		for (i = 0; i < n; i++) begin
			for (k = 0; k < LIT_BITS; k++) b[LIT_BITS-1-k] = tx_bits[LIT_BITS*i+k];
			send_word(b, s && i == 0, e && i == n - 1);
		end
		tx_bits.delete();
	endtask

	// well-formed stream, matches mostly point back into bytes already produced
	task automatic random_stream();
		int tokens;
		int made;
		int gap;
		int pos;
		int len;
		int i;
		tokens = $urandom_range(2, 14);
		made = 0;
		for (i = 0; i < tokens; i++) begin
			if (made == 0 || $urandom_range(99) < 40) begin
				push_literal($urandom_range(255));
				made++;
			end else begin
				if (made > 24 && $urandom_range(3) == 0) begin
					gap = $urandom_range(1, made);
				end else begin
					gap = $urandom_range(1, (made < 24) ? made : 24);
				end
				if ($urandom_range(19) == 0) begin
					pos = $urandom_range(1, RING_DEPTH - 1);
				end else begin
					pos = (1 + made - gap) % RING_DEPTH;
				end
				len = $urandom_range((1 << LEN_BITS) - 1);
				push_match(pos, len);
				made += len + MIN_MATCH;
			end
		end
		if ($urandom_range(3) == 0) begin
			push_terminator();
		end
		send_packed(1'b1, $urandom_range(99) < 60);
	endtask

	task automatic noise_burst();
		int n;
		int i;
		n = $urandom_range(1, 6);
		for (i = 0; i < n; i++) begin
			send_word(LIT_BITS'($urandom_range(255)), i == 0 && $urandom_range(1) == 1,
				$urandom_range(3) == 0);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		comp_byte = '0;
		stream_start = 1'b0;
		stream_end = 1'b0;
		out_stall = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// size is zero out of reset: done at once, following word dropped
		send_word(8'hA5, 1'b0, 1'b0);
		send_word(8'h00, 1'b0, 1'b0);

		write_size('1);
		// literal, then padding runs into a terminator
		send_word(8'hC3, 1'b1, 1'b1);
		push_literal(8'h00);
		push_literal(8'hFF);
		push_match(1, (1 << LEN_BITS) - 1);
		push_match(RING_DEPTH - 1, 0);
		push_match(5000, 0);
		push_terminator();
		send_packed(1'b1, 1'b1);
		send_word(8'hFF, 1'b0, 1'b0);

		// size reached part way through a copy
		write_size(5);
		push_literal(8'h3C);
		push_match(1, (1 << LEN_BITS) - 1);
		send_packed(1'b1, 1'b0);

		write_size(1);
		send_word(8'h80, 1'b1, 1'b1);

		// size lowered below the count mid-stream
		write_size('1);
		push_literal(8'h11);
		push_literal(8'h22);
		push_field(1, 1);
		push_field(8'h33 >> 2, 6);
		send_packed(1'b1, 1'b0);
		write_size(2);
		send_word(8'h55, 1'b0, 1'b0);

		while (words_sent < WORD_TARGET) begin
			case ($urandom_range(7))
				0: begin
					write_size('0);
				end
				1: begin
					write_size('1);
				end
				2, 3: begin
					write_size(SIZE_W'($urandom_range(1, 8)));
				end
				4, 5, 6: begin
					write_size(SIZE_W'($urandom_range(10, 150)));
				end
				default: begin
					write_size(SIZE_W'($urandom_range(256, 24'hFFFFFE)));
				end
			endcase
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(9) == 0) begin
					noise_burst();
				end else begin
					random_stream();
				end
			end
		end

		settle();
		if (sb.n_fail == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
